[rtl/core/hga_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hga_pkg
// Shared types, sizes and codes for the generational handle allocator.
// ----------------------------------------------------------------------------
package hga_pkg;

  // table sizes
  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = SLOT_W + 1;
  localparam int IDX_W  = 10;
  localparam int VER_W  = 16;

  // command codes
  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_STALE = 2'd2;

  // request item
  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] slot_index;
    logic [VER_W-1:0] slot_version;
  } req_t;

  // response item
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] out_index;
    logic [VER_W-1:0] out_version;
    logic             is_live;
  } rsp_t;

  // free stack control from the execute logic
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [SLOT_W-1:0] push_slot;
  } stk_ctrl_t;

  // free stack status toward the execute logic
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SLOT_W-1:0] top;
  } stk_stat_t;

endpackage

[rtl/core/generational_handle_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out, retires and checks slot handles made of an index and a version.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req / req_valid / req_stall carries one command per item:
//   create, destroy or check. Response channel rsp / rsp_valid / rsp_stall
//   returns exactly one item per request, in request order.
//   An accepted item sits in the input register, and its response is then
//   registered into the output register that drives rsp. Throughput is one
//   item per cycle while rsp_stall is low: the version of a destroy or check
//   is read at the accepting edge, the stack top is prefetched every cycle, and
//   a popped slot's version is read on a second memory port while the response sits in the output register.
//   When rsp_stall is high with a response pending, the item in the input
//   register waits and req_stall rises; one item is held on each side.
//   Reset clears the free count, the high-water count and both valid flags.
//   The version and stack memories are not cleared: only entries below the
//   high-water count or below the free count are ever used.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic          clk,
  input  logic          rst,
  input  hga_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output hga_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);

  hga_pkg::req_t               in_q;
  logic                        in_vld;
  hga_pkg::rsp_t               out_q;
  logic                        out_vld;
  logic                        out_use_b;
  logic [hga_pkg::CNT_W-1:0]   high_water;
  logic [hga_pkg::CNT_W-1:0]   high_water_next;

  logic                        accept;
  logic                        advance;

  hga_pkg::stk_ctrl_t          stk_ctrl;
  hga_pkg::stk_stat_t          stk_stat;

  logic                        ver_wr_en;
  logic [hga_pkg::SLOT_W-1:0]  ver_wr_addr;
  logic [hga_pkg::VER_W-1:0]   ver_wr_data;
  logic [hga_pkg::VER_W-1:0]   ver_a;
  logic                        ver_b_en;
  logic [hga_pkg::VER_W-1:0]   ver_b;

  hga_pkg::rsp_t               res;
  logic                        res_use_b;
  logic                        in_range;
  logic                        live;
  logic [hga_pkg::VER_W-1:0]   stored;
  logic [hga_pkg::SLOT_W-1:0]  in_slot;

  // handshake
  assign accept    = req_valid && !req_stall;
  assign advance   = in_vld && (!out_vld || !rsp_stall);
  assign req_stall = in_vld && !advance;

  assign in_slot = hga_pkg::SLOT_W'(in_q.slot_index);

  // execute: decide result and state updates for the item in the input register
  always_comb begin
    res             = '0;
    res_use_b       = 1'b0;
    stk_ctrl        = '0;
    ver_wr_en       = 1'b0;
    ver_wr_addr     = in_slot;
    ver_wr_data     = '0;
    high_water_next = high_water;
    in_range        = (hga_pkg::CNT_W'(in_q.slot_index) < high_water);
    stored          = in_range ? ver_a : '0;
    live            = in_range && (stored == in_q.slot_version);
    case (in_q.cmd)
      hga_pkg::CMD_CREATE: begin
        if (stk_stat.count != '0) begin
          // reuse the most recently freed slot
          stk_ctrl.pop  = advance;
          res.out_index = hga_pkg::IDX_W'(stk_stat.top);
          res_use_b     = 1'b1;
        end else if (high_water < hga_pkg::CNT_W'(hga_pkg::SLOTS)) begin
          // take a never-used slot at version one
          res.out_index   = hga_pkg::IDX_W'(high_water);
          res.out_version = hga_pkg::VER_W'(1);
          ver_wr_en       = advance;
          ver_wr_addr     = high_water[hga_pkg::SLOT_W-1:0];
          ver_wr_data     = hga_pkg::VER_W'(1);
          if (advance) begin
            high_water_next = high_water + hga_pkg::CNT_W'(1);
          end
        end else begin
          res.status = hga_pkg::ST_FULL;
        end
      end
      hga_pkg::CMD_DESTROY, hga_pkg::CMD_CHECK: begin
        res.out_index   = in_q.slot_index;
        res.out_version = stored;
        res.is_live     = live;
        res.status      = live ? hga_pkg::ST_OK : hga_pkg::ST_STALE;
        // retire: bump version and free the slot
        if (live && (in_q.cmd == hga_pkg::CMD_DESTROY)) begin
          ver_wr_en          = advance;
          ver_wr_data        = stored + hga_pkg::VER_W'(1);
          stk_ctrl.push      = advance &&
                               (stk_stat.count < hga_pkg::CNT_W'(hga_pkg::SLOTS));
          stk_ctrl.push_slot = in_slot;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign ver_b_en = advance && res_use_b;

  // version store
  hga_version_mem u_ver (
    .clk       (clk),
    .wr_en     (ver_wr_en),
    .wr_addr   (ver_wr_addr),
    .wr_data   (ver_wr_data),
    .rd_a_en   (accept),
    .rd_a_addr (hga_pkg::SLOT_W'(req.slot_index)),
    .rd_a_data (ver_a),
    .rd_b_en   (ver_b_en),
    .rd_b_addr (stk_stat.top),
    .rd_b_data (ver_b)
  );

  // free slot stack
  hga_free_stack u_stk (
    .clk  (clk),
    .rst  (rst),
    .ctrl (stk_ctrl),
    .stat (stk_stat)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld     <= 1'b0;
      out_vld    <= 1'b0;
      high_water <= '0;
    end else begin
      high_water <= high_water_next;
      if (accept) begin
        in_vld <= 1'b1;
      end else if (advance) begin
        in_vld <= 1'b0;
      end
      if (advance) begin
        out_vld <= 1'b1;
      end else if (!rsp_stall) begin
        out_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= req;
    end
    if (advance) begin
      out_q     <= res;
      out_use_b <= res_use_b;
    end
  end

  // response: a reused slot takes its version from the second read port
  always_comb begin
    rsp = out_q;
    if (out_use_b) begin
      rsp.out_version = ver_b;
    end
  end
  assign rsp_valid = out_vld;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stk_stat.count <= hga_pkg::CNT_W'(hga_pkg::SLOTS))
    else $error("free count above slot count");

  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= hga_pkg::CNT_W'(hga_pkg::SLOTS))
    else $error("high-water count above slot count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    stk_ctrl.pop |-> (stk_stat.count != '0) && !stk_ctrl.push)
    else $error("pop from empty stack or pop with push");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_vld && rsp_stall) |-> !advance)
    else $error("execute advanced over a stalled response");

  a_live_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_live) |-> (rsp.status == hga_pkg::ST_OK))
    else $error("live handle reported with error status");

endmodule

[rtl/core/hga_free_stack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hga_free_stack
// LIFO of freed slot indexes in a memory, with the top entry always ready.
// ----------------------------------------------------------------------------
module hga_free_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  hga_pkg::stk_ctrl_t    ctrl,
  output hga_pkg::stk_stat_t    stat
);

  logic [hga_pkg::SLOT_W-1:0] mem [hga_pkg::SLOTS];
  logic [hga_pkg::CNT_W-1:0]  count;
  logic [hga_pkg::CNT_W-1:0]  count_next;
  logic [hga_pkg::CNT_W-1:0]  top_ptr;
  logic [hga_pkg::SLOT_W-1:0] rd_addr;
  logic [hga_pkg::SLOT_W-1:0] rd_q;
  logic                       byp_vld;
  logic [hga_pkg::SLOT_W-1:0] byp_data;

  // fill count after this cycle's push or pop
  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + hga_pkg::CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - hga_pkg::CNT_W'(1);
    end
  end

  // prefetch the entry that will be on top next cycle
  assign top_ptr = count_next - hga_pkg::CNT_W'(1);
  assign rd_addr = top_ptr[hga_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      byp_vld <= 1'b0;
    end else begin
      count   <= count_next;
      byp_vld <= ctrl.push;
    end
  end

  // memory write and registered read; a fresh push bypasses the read
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[count[hga_pkg::SLOT_W-1:0]] <= ctrl.push_slot;
    end
    rd_q     <= mem[rd_addr];
    byp_data <= ctrl.push_slot;
  end

  assign stat.count = count;
  assign stat.top   = byp_vld ? byp_data : rd_q;

endmodule

[rtl/core/hga_version_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hga_version_mem
// Per-slot version store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hga_version_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [hga_pkg::SLOT_W-1:0] wr_addr,
  input  logic [hga_pkg::VER_W-1:0]  wr_data,
  input  logic                       rd_a_en,
  input  logic [hga_pkg::SLOT_W-1:0] rd_a_addr,
  output logic [hga_pkg::VER_W-1:0]  rd_a_data,
  input  logic                       rd_b_en,
  input  logic [hga_pkg::SLOT_W-1:0] rd_b_addr,
  output logic [hga_pkg::VER_W-1:0]  rd_b_data
);

  logic [hga_pkg::VER_W-1:0] mem [hga_pkg::SLOTS];

  // port a returns the value being written in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_data <= (wr_en && (wr_addr == rd_a_addr)) ? wr_data : mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule
